/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hw/rtl/wsmd_pkg.sv */
// Package for the wave stream to mono decoder: payload types, codes, constants.
// Depends on nothing.
package wsmd_pkg;
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } wsmd_in_t;

    typedef struct packed {
        logic signed [23:0] sample;
        logic [31:0]        sample_rate;
        logic               last;
    } wsmd_out_t;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HEAD = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_DONE = 3'd5
    } wsmd_phase_t;

    typedef enum logic [1:0] {
        CS_IDLE  = 2'd0,
        CS_FRAME = 2'd1,
        CS_DIV   = 2'd2,
        CS_OUT   = 2'd3
    } wsmd_ctl_t;

    localparam logic [31:0] TAG_FMT      = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
    localparam logic [31:0] DEFAULT_RATE = 32'd48000;
    localparam int          DIV_BITS     = 41;
    localparam int          CNT_W        = 6;

    // Commands from controller to datapath, status back.
    typedef struct packed {
        logic take_byte;
        logic frame_start;
        logic div_start;
        logic div_step;
        logic frame_div_start;
        logic frame_div_step;
        logic out_load;
    } wsmd_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic frame_sized;
        logic last_frame;
        logic fin;
    } wsmd_sts_t;

    // IEEE single to Q1.23, truncating toward zero with saturation.
    function automatic logic signed [23:0] float_to_q23(input logic [31:0] w);
        logic [7:0]  ex;
        logic [22:0] man;
        logic [23:0] mag;
        logic [7:0]  sh;
        ex  = w[30:23];
        man = w[22:0];
        sh  = 8'd127 - ex;
        mag = {1'b1, man} >> sh[4:0];
        if (ex == 8'hFF && man != 23'd0)
            return 24'sd0;
        else if (ex >= 8'd127)
            return w[31] ? 24'sh800000 : 24'sh7FFFFF;
        else if (ex == 8'd0 || sh >= 8'd24)
            return 24'sd0;
        else
            return w[31] ? -$signed(mag) : $signed(mag);
    endfunction
endpackage

/* hw/rtl/wave_stream_to_mono_decoder_top.sv */
// Channel    | Ports                                  | Payload
// input      | s_valid, s_ready, s_data               | in_byte, in_last
// result     | m_valid, m_ready, m_data               | sample, sample_rate, last
// Each byte is checked in the frame state before the next is taken. One that
// completes a frame or the data chunk header also runs the 41-step shared
// divider first. Bytes keep flowing while a word waits on m_ready; the next
// finished frame holds the input until that word is taken.
// Reset is synchronous on aresetn and returns the parser to the RIFF header.
// Top level of the wave stream decoder. Depends on wsmd_pkg, wsmd_ctrl,
// wsmd_datapath and assert_macros.svh.
module wave_stream_to_mono_decoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wsmd_pkg::wsmd_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output wsmd_pkg::wsmd_out_t m_data
);
    import wsmd_pkg::*;
    `include "assert_macros.svh"

    wsmd_cmd_t cmd;
    wsmd_sts_t sts;

    wsmd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    wsmd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_word(s_data), .cmd(cmd),
        .sts(sts), .out_word(m_data)
    );

    `CHK_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")
    `CHK_IMPL(a_load_free, aclk, aresetn, cmd.out_load, !m_valid || m_ready, "result loaded over a pending word")
    `CHK_IMPL(a_no_take_busy, aclk, aresetn, cmd.take_byte, !cmd.div_step && !cmd.frame_div_step, "byte taken during division")
endmodule

/* hw/rtl/wsmd_datapath.sv */
// Datapath of the wave decoder: chunk parser registers, sample conversion,
// frame accumulator, one shared frame-count and average divider. Depends on wsmd_pkg.
module wsmd_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  wsmd_pkg::wsmd_in_t  in_word,
    input  wsmd_pkg::wsmd_cmd_t cmd,
    output wsmd_pkg::wsmd_sts_t sts,
    output wsmd_pkg::wsmd_out_t out_word
);
    import wsmd_pkg::*;

    wsmd_phase_t phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] tag_reg, tag_next, len_reg, len_next;
    logic [32:0] left_reg, left_next;
    logic [15:0] fmt_reg, fmt_next, chans_reg, chans_next, bits_reg, bits_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] asm_reg, asm_next;
    logic [15:0] bis_reg, bis_next, chidx_reg, chidx_next;
    logic signed [39:0] sum_reg, sum_next;
    logic [31:0] frames_reg, frames_next;
    logic        fin_reg, fin_next;
    logic        done_reg, done_next, sized_reg, sized_next, lastf_reg, lastf_next;
    // Shared restoring divider: quotient builds up in dnum, remainder in drem.
    logic [DIV_BITS-1:0] dnum_reg, dnum_next;
    logic [DIV_BITS:0]   drem_reg, drem_next;
    logic [DIV_BITS-1:0] dden_reg, dden_next;
    logic                dneg_reg, dneg_next;
    logic [DIV_BITS:0]   trial;
    wsmd_out_t           out_reg, out_next;

    logic [7:0]  b;
    logic [32:0] body;
    logic [32:0] k33;
    logic [2:0]  hk;
    logic [15:0] bps;
    logic [31:0] raw;
    logic signed [23:0] conv;
    logic signed [31:0] s32;
    logic [39:0] sum_abs;

    assign b    = in_word.in_byte;
    assign body = {1'b0, len_reg} + {32'd0, len_reg[0]};
    assign k33  = body - left_reg;
    assign hk   = 3'(4'd8 - left_reg[3:0]);
    assign bps  = {3'd0, bits_reg[15:3]};
    assign trial = {drem_reg[DIV_BITS-1:0], dnum_reg[DIV_BITS-1]} - {1'b0, dden_reg};

    // The sample being finished includes the byte taken in this cycle.
    always_comb begin
        raw = asm_reg;
        if (bis_reg < 16'd4) raw[8*bis_reg[1:0] +: 8] = b;
        s32 = $signed(raw);
        if (fmt_reg == 16'd3 && bits_reg == 16'd32)
            conv = float_to_q23(raw);
        else if (bits_reg == 16'd16)
            conv = {raw[15:0], 8'd0};
        else if (bits_reg == 16'd24)
            conv = raw[23:0];
        else if (bits_reg == 16'd32)
            conv = 24'((s32 + (s32[31] ? 32'sd255 : 32'sd0)) >>> 8);
        else
            conv = 24'sd0;
    end

    always_comb begin
        phase_next = phase_reg; offset_next = offset_reg; tag_next = tag_reg;
        len_next = len_reg; left_next = left_reg; fmt_next = fmt_reg;
        chans_next = chans_reg; bits_next = bits_reg; rate_next = rate_reg;
        asm_next = asm_reg; bis_next = bis_reg; chidx_next = chidx_reg;
        sum_next = sum_reg; frames_next = frames_reg; fin_next = fin_reg;
        done_next = 1'b0; sized_next = 1'b0; lastf_next = lastf_reg;
        dnum_next = dnum_reg; drem_next = drem_reg; dden_next = dden_reg;
        dneg_next = dneg_reg; out_next = out_reg;
        sum_abs = sum_reg[39] ? 40'(-sum_reg) : 40'(sum_reg);
        if (cmd.take_byte) begin
            fin_next = in_word.in_last;
            offset_next = offset_reg + 32'd1;
            unique case (phase_reg)
                PH_RIFF: begin
                    if (offset_reg >= 32'd11) begin
                        phase_next = PH_HEAD; left_next = 33'd8;
                        tag_next = '0; len_next = '0;
                    end
                end
                PH_HEAD: begin
                    if (!hk[2]) tag_next[8*hk[1:0] +: 8] = b;
                    else        len_next[8*hk[1:0] +: 8] = b;
                    left_next = left_reg - 33'd1;
                    if (left_reg == 33'd1) begin
                        if (tag_next == TAG_DATA) begin
                            // Frame count comes from the shared divider.
                            asm_next = '0; bis_next = '0; chidx_next = '0;
                            sum_next = '0;
                            left_next = {1'b0, len_next};
                            phase_next = PH_DATA;
                            dnum_next = {9'd0, len_next};
                            dden_next = 41'({16'd0, bps} * {16'd0, chans_reg});
                            drem_next = '0;
                            sized_next = 1'b1;
                        end else if (len_next == 32'd0) begin
                            phase_next = PH_HEAD; left_next = 33'd8;
                            tag_next = '0; len_next = '0;
                        end else begin
                            left_next = {1'b0, len_next} + {32'd0, len_next[0]};
                            phase_next = (tag_next == TAG_FMT) ? PH_FMT : PH_SKIP;
                        end
                    end
                end
                PH_FMT, PH_SKIP: begin
                    if (phase_reg == PH_FMT && k33 < {1'b0, len_reg} && k33 < 33'd16) begin
                        if (k33[3:0] < 4'd2)      fmt_next[8*k33[0] +: 8] = b;
                        else if (k33[3:0] < 4'd4) chans_next[8*k33[0] +: 8] = b;
                        else if (k33[3:0] < 4'd8) rate_next[8*k33[1:0] +: 8] = b;
                        else if (k33[3:0] >= 4'd14) bits_next[8*k33[0] +: 8] = b;
                    end
                    left_next = left_reg - 33'd1;
                    if (left_reg == 33'd1) begin
                        phase_next = PH_HEAD; left_next = 33'd8;
                        tag_next = '0; len_next = '0;
                    end
                end
                PH_DATA: begin
                    if (bis_reg < 16'd4) asm_next[8*bis_reg[1:0] +: 8] = b;
                    bis_next = bis_reg + 16'd1;
                    if (bis_next >= bps) begin
                        sum_next = sum_reg + 40'(conv);
                        asm_next = '0; bis_next = '0;
                        chidx_next = chidx_reg + 16'd1;
                        if (chidx_next >= chans_reg) begin
                            chidx_next = '0;
                            frames_next = frames_reg - 32'd1;
                            lastf_next = (frames_next == 32'd0);
                            if (frames_next == 32'd0) phase_next = PH_DONE;
                            done_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (cmd.frame_div_start) begin
            dnum_next = {1'b0, sum_abs};
            dneg_next = sum_reg[39];
            dden_next = {25'd0, chans_reg};
            drem_next = '0;
            sum_next = '0;
        end
        if (cmd.div_step || cmd.frame_div_step) begin
            if (!trial[DIV_BITS]) drem_next = trial;
            else drem_next = {drem_reg[DIV_BITS-1:0], dnum_reg[DIV_BITS-1]};
            dnum_next = {dnum_reg[DIV_BITS-2:0], ~trial[DIV_BITS]};
        end
        if (cmd.div_start) begin
            // Quotient left in dnum; zero divisor gives no frames.
            frames_next = (dden_reg == '0) ? 32'd0 : dnum_reg[31:0];
            if (dden_reg == '0 || dnum_reg[31:0] == 32'd0) phase_next = PH_DONE;
        end
        if (cmd.out_load) begin
            out_next.sample = dneg_reg ? 24'(-dnum_reg) : dnum_reg[23:0];
            out_next.sample_rate = rate_reg;
            out_next.last = lastf_reg;
        end
        if (cmd.frame_start) begin
            // End of file: parser and accumulator registers back to their reset values.
            phase_next = PH_RIFF; offset_next = '0; tag_next = '0; len_next = '0;
            left_next = '0; fmt_next = 16'd1; chans_next = 16'd1;
            rate_next = DEFAULT_RATE; bits_next = 16'd16; asm_next = '0;
            bis_next = '0; chidx_next = '0; sum_next = '0; frames_next = '0;
            fin_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RIFF; offset_reg <= '0; tag_reg <= '0; len_reg <= '0;
            left_reg <= '0; fmt_reg <= 16'd1; chans_reg <= 16'd1;
            rate_reg <= DEFAULT_RATE; bits_reg <= 16'd16; asm_reg <= '0;
            bis_reg <= '0; chidx_reg <= '0; sum_reg <= '0; frames_reg <= '0;
            fin_reg <= 1'b0; done_reg <= 1'b0; sized_reg <= 1'b0;
            lastf_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; offset_reg <= offset_next; tag_reg <= tag_next;
            len_reg <= len_next; left_reg <= left_next; fmt_reg <= fmt_next;
            chans_reg <= chans_next; rate_reg <= rate_next; bits_reg <= bits_next;
            asm_reg <= asm_next; bis_reg <= bis_next; chidx_reg <= chidx_next;
            sum_reg <= sum_next; frames_reg <= frames_next; fin_reg <= fin_next;
            done_reg <= done_next; sized_reg <= sized_next; lastf_reg <= lastf_next;
        end
    end

    always_ff @(posedge aclk) begin
        dnum_reg <= dnum_next; drem_reg <= drem_next; dden_reg <= dden_next;
        dneg_reg <= dneg_next; out_reg <= out_next;
    end

    assign sts.frame_done  = done_reg;
    assign sts.frame_sized = sized_reg;
    assign sts.last_frame  = lastf_reg;
    assign sts.fin         = fin_reg;
    assign out_word        = out_reg;
endmodule

/* hw/rtl/wsmd_ctrl.sv */
// Controller of the wave decoder: sequences byte intake, the shared divider
// and the result register. Depends on wsmd_pkg.
module wsmd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  wsmd_pkg::wsmd_sts_t sts,
    output wsmd_pkg::wsmd_cmd_t cmd
);
    import wsmd_pkg::*;

    wsmd_ctl_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             is_frame_reg, is_frame_next;
    logic             mv_reg, mv_next;
    logic             fin_pend_reg, fin_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE; cnt_reg <= '0; is_frame_reg <= 1'b0;
            mv_reg <= 1'b0; fin_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next; cnt_reg <= cnt_next;
            is_frame_reg <= is_frame_next; mv_reg <= mv_next;
            fin_pend_reg <= fin_pend_next;
        end
    end

    always_comb begin
        state_next = state_reg; cnt_next = cnt_reg; is_frame_next = is_frame_reg;
        mv_next = mv_reg; fin_pend_next = fin_pend_reg;
        cmd = '0; s_ready = 1'b0;
        if (mv_reg && m_ready) mv_next = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                cmd.take_byte = s_valid;
                if (s_valid) state_next = CS_FRAME;
            end
            CS_FRAME: begin
                // In the cycle after a byte is taken: see what it triggered.
                if (sts.frame_done) begin
                    cmd.frame_div_start = 1'b1; is_frame_next = 1'b1;
                    cnt_next = CNT_W'(DIV_BITS); state_next = CS_DIV;
                    fin_pend_next = sts.fin;
                end else if (sts.frame_sized) begin
                    is_frame_next = 1'b0;
                    cnt_next = CNT_W'(DIV_BITS); state_next = CS_DIV;
                    fin_pend_next = sts.fin;
                end else begin
                    cmd.frame_start = sts.fin;
                    state_next = CS_IDLE;
                end
            end
            CS_DIV: begin
                if (cnt_reg != '0) begin
                    cmd.frame_div_step = is_frame_reg;
                    cmd.div_step = !is_frame_reg;
                    cnt_next = cnt_reg - CNT_W'(1);
                end else if (!is_frame_reg) begin
                    cmd.div_start = 1'b1;
                    cmd.frame_start = fin_pend_reg;
                    state_next = CS_IDLE;
                end else if (!mv_next) begin
                    cmd.out_load = 1'b1; mv_next = 1'b1;
                    state_next = CS_OUT;
                end
            end
            CS_OUT: begin
                cmd.frame_start = fin_pend_reg;
                state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    assign m_valid = mv_reg;
endmodule
